>>> rtl/core/trm_pkg.sv
// Shared types and constants for the tiny register machine execute core.
// No dependencies; imported by the core and its register file.
package trm_pkg;

	localparam int WORD_W     = 32;
	localparam int PC_W       = 9;
	localparam int IMM_W      = 16;
	localparam int FIELD_W    = 3;
	localparam int SUM_W      = 18;
	localparam int PC_LIMIT   = 256;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register index, taken from the word-address bit of paddr
	localparam logic REG_PROG_LEN = 1'b0;

	typedef enum logic [FIELD_W-1:0] {
		CMD_J    = 3'd0,
		CMD_PRT  = 3'd1,
		CMD_BEQZ = 3'd2,
		CMD_ADDI = 3'd3,
		CMD_SLT  = 3'd4,
		CMD_ADD  = 3'd5,
		CMD_SUB  = 3'd6
	} cmd_t;

endpackage

>>> rtl/core/trm_regfile.sv
// Register file: synchronous memory with registered reads, two read ports,
// one write port, per-entry valid bits for the zero reset, write-to-read bypass.
// Depends on trm_pkg.
module trm_regfile #(
	parameter int NUM_REGS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rd_en,
	input  logic [$clog2(NUM_REGS)-1:0]          rd_addr_a,
	input  logic [$clog2(NUM_REGS)-1:0]          rd_addr_b,
	output logic [trm_pkg::WORD_W-1:0]           rd_data_a,
	output logic [trm_pkg::WORD_W-1:0]           rd_data_b,
	input  logic                                 wr_en,
	input  logic [$clog2(NUM_REGS)-1:0]          wr_addr,
	input  logic [trm_pkg::WORD_W-1:0]           wr_data
);
	import trm_pkg::*;

	logic [WORD_W-1:0] mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;

	logic [WORD_W-1:0] mem_a_s1;
	logic [WORD_W-1:0] mem_b_s1;
	logic [WORD_W-1:0] fwd_data_s1;
	logic              ok_a_s1;
	logic              ok_b_s1;
	logic              fwd_a_s1;
	logic              fwd_b_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_a_s1    <= mem[rd_addr_a];
			mem_b_s1    <= mem[rd_addr_b];
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			ok_a_s1  <= 1'b0;
			ok_b_s1  <= 1'b0;
			fwd_a_s1 <= 1'b0;
			fwd_b_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				ok_a_s1  <= valid_q[rd_addr_a];
				ok_b_s1  <= valid_q[rd_addr_b];
				// the memory returns old data when written in the same cycle
				fwd_a_s1 <= wr_en && (wr_addr == rd_addr_a);
				fwd_b_s1 <= wr_en && (wr_addr == rd_addr_b);
			end
		end
	end

	always_comb begin
		if (fwd_a_s1) begin
			rd_data_a = fwd_data_s1;
		end else if (ok_a_s1) begin
			rd_data_a = mem_a_s1;
		end else begin
			rd_data_a = '0;
		end
		if (fwd_b_s1) begin
			rd_data_b = fwd_data_s1;
		end else if (ok_b_s1) begin
			rd_data_b = mem_b_s1;
		end else begin
			rd_data_b = '0;
		end
	end

endmodule

>>> rtl/core/tiny_register_machine_execute_core.sv
// Execute core of a tiny register machine with a program counter.
// Depends on trm_pkg and trm_regfile.
//
// Usage: the host fetches the instruction at the last reported next_pc and
// sends it as one request on the in channel (valid/ready). Each request gives
// exactly one result on the out channel: next_pc, halted, and the printed
// register for PRT. Program length is written through the APB port (register
// 0 at byte address 0) by the host while the core is idle; it is not enforced.
//
// The accepting edge reads both source registers from the register file
// memory; in the next cycle the core executes, and the edge on which the
// execute stage advances writes the destination back and loads the output
// register. Throughput: one request per cycle unless the receiver stalls.
// A write is bypassed to a read issued in the same cycle, so dependent
// instructions follow back to back. Reset clears all registers, the pc and
// the halt flag; with a program length of zero the core reports halted.
// Once a jump or step leaves the program, requests are consumed without
// effect until reset. If the receiver stalls, the result holds in the output
// register, one more request waits in the execute stage, and in_ready drops.
module tiny_register_machine_execute_core #(
	parameter int NUM_REGS   = 8,
	parameter int PROG_DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [trm_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [trm_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [trm_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [trm_pkg::FIELD_W-1:0]          command,
	input  logic [trm_pkg::FIELD_W-1:0]          dst_reg,
	input  logic [trm_pkg::FIELD_W-1:0]          src1_reg,
	input  logic [trm_pkg::FIELD_W-1:0]          src2_reg,
	input  logic signed [trm_pkg::IMM_W-1:0]     immediate,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [trm_pkg::PC_W-1:0]             next_pc,
	output logic                                 halted,
	output logic                                 print_valid,
	output logic signed [trm_pkg::WORD_W-1:0]    print_value
);
	import trm_pkg::*;

	localparam int RIDX_W = $clog2(NUM_REGS);
	localparam int PC_MAX = (1 << PC_W) - 1;
	localparam int CAP_INT = (PROG_DEPTH > PC_MAX) ? PC_MAX : PROG_DEPTH;
	localparam logic [PC_W-1:0] DEPTH_CAP = PC_W'(CAP_INT);

	// Wrap a register field into the implemented register count
	function automatic logic [RIDX_W-1:0] reg_idx(input logic [FIELD_W-1:0] f);
		logic [5:0] v;
		v = {{(6-FIELD_W){1'b0}}, f};
		for (int i = 0; i < 4; i++) begin
			if (v >= 6'(NUM_REGS)) begin
				v = v - 6'(NUM_REGS);
			end
		end
		return v[RIDX_W-1:0];
	endfunction

	// Configuration
	logic [PC_W-1:0] prog_len_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[APB_ADDR_W-1] == REG_PROG_LEN);
	assign prdata = (paddr[APB_ADDR_W-1] == REG_PROG_LEN)
		? {{(APB_DATA_W-PC_W){1'b0}}, prog_len_q} : '0;

	// Pipeline control
	logic              v_s1;
	logic              out_valid_q;
	logic              adv;
	logic              in_acc;
	cmd_t              cmd_s1;
	logic [RIDX_W-1:0] dst_s1;
	logic [IMM_W-1:0]  imm_s1;

	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	// Architectural state outside the register file
	logic [PC_W-1:0] pc_q;
	logic            halt_q;

	// Register file
	logic [WORD_W-1:0] a_val;
	logic [WORD_W-1:0] b_val;
	logic              wr_en;
	logic [WORD_W-1:0] wr_data;

	trm_regfile #(
		.NUM_REGS(NUM_REGS)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_acc),
		.rd_addr_a(reg_idx(src1_reg)),
		.rd_addr_b(reg_idx(src2_reg)),
		.rd_data_a(a_val),
		.rd_data_b(b_val),
		.wr_en    (wr_en),
		.wr_addr  (dst_s1),
		.wr_data  (wr_data)
	);

	// Execute
	logic [PC_W-1:0]         eff_len;
	logic                    halted_now;
	logic signed [SUM_W-1:0] pc_ext;
	logic signed [SUM_W-1:0] imm_ext;
	logic signed [SUM_W-1:0] pc_new;
	logic                    leave;
	logic                    take_br;
	logic                    wr_req;
	logic                    prt;
	logic [PC_W-1:0]         nxt_pc;
	logic                    nxt_halt;

	assign eff_len    = (prog_len_q > DEPTH_CAP) ? DEPTH_CAP : prog_len_q;
	assign halted_now = halt_q || (pc_q >= eff_len);
	assign pc_ext     = {{(SUM_W-PC_W){1'b0}}, pc_q};
	assign imm_ext    = {{(SUM_W-IMM_W){imm_s1[IMM_W-1]}}, imm_s1};

	always_comb begin
		take_br = 1'b0;
		wr_req  = 1'b0;
		prt     = 1'b0;
		wr_data = '0;
		case (cmd_s1)
			CMD_J: begin
				take_br = 1'b1;
			end
			CMD_PRT: begin
				prt = 1'b1;
			end
			CMD_BEQZ: begin
				take_br = (a_val == '0);
			end
			CMD_ADDI: begin
				wr_req  = 1'b1;
				wr_data = a_val + {{(WORD_W-IMM_W){imm_s1[IMM_W-1]}}, imm_s1};
			end
			CMD_SLT: begin
				wr_req  = 1'b1;
				wr_data = {{(WORD_W-1){1'b0}}, ($signed(b_val) > $signed(a_val))};
			end
			CMD_ADD: begin
				wr_req  = 1'b1;
				wr_data = a_val + b_val;
			end
			CMD_SUB: begin
				wr_req  = 1'b1;
				wr_data = a_val - b_val;
			end
			default: begin
			end
		endcase
	end

	assign pc_new = take_br ? (pc_ext + imm_ext) : (pc_ext + SUM_W'(1));
	assign leave  = pc_new[SUM_W-1]
		|| (pc_new[SUM_W-2:0] >= {{(SUM_W-1-PC_W){1'b0}}, eff_len});
	assign wr_en  = adv && !halted_now && wr_req;

	always_comb begin
		if (halted_now) begin
			nxt_pc   = pc_q;
			nxt_halt = 1'b1;
		end else if (leave) begin
			nxt_pc   = eff_len;
			nxt_halt = 1'b1;
		end else begin
			nxt_pc   = pc_new[PC_W-1:0];
			nxt_halt = 1'b0;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_len_q  <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
			halt_q      <= 1'b0;
		end else begin
			if (cfg_wr) begin
				prog_len_q <= pwdata[PC_W-1:0];
			end
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv && !halted_now) begin
				pc_q   <= nxt_pc;
				halt_q <= nxt_halt;
			end
		end
	end

	// Payload registers
	logic [PC_W-1:0]   next_pc_q;
	logic              halted_q;
	logic              print_valid_q;
	logic [WORD_W-1:0] print_value_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= cmd_t'(command);
			dst_s1 <= reg_idx(dst_reg);
			imm_s1 <= immediate;
		end
		if (adv) begin
			next_pc_q     <= nxt_pc;
			halted_q      <= nxt_halt;
			print_valid_q <= prt && !halted_now;
			print_value_q <= (prt && !halted_now) ? a_val : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign next_pc     = next_pc_q;
	assign halted      = halted_q;
	assign print_valid = print_valid_q;
	assign print_value = print_value_q;

	// Checks
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared without reset");

	a_halt_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> $stable(pc_q))
		else $error("pc moved while halted");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(cmd_s1))
		else $error("stalled request lost from execute stage");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(next_pc_q)
			&& $stable(halted_q) && $stable(print_valid_q) && $stable(print_value_q))
		else $error("result changed while the receiver stalled");

endmodule

>>> test/trm_execute_checker.sv
// Checker for the tiny register machine execute core: watches the APB port, the
// request and result channels, predicts each result and compares it field by field.
// Depends on trm_pkg; instantiated beside the core by the testbench top.
module trm_execute_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [trm_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [trm_pkg::APB_DATA_W-1:0]     pwdata,
	input  logic                               pready,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [trm_pkg::FIELD_W-1:0]        command,
	input  logic [trm_pkg::FIELD_W-1:0]        dst_reg,
	input  logic [trm_pkg::FIELD_W-1:0]        src1_reg,
	input  logic [trm_pkg::FIELD_W-1:0]        src2_reg,
	input  logic signed [trm_pkg::IMM_W-1:0]   immediate,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [trm_pkg::PC_W-1:0]           next_pc,
	input  logic                               halted,
	input  logic                               print_valid,
	input  logic signed [trm_pkg::WORD_W-1:0]  print_value,
	output logic [trm_pkg::PC_W-1:0]           pc_ahead,
	output int unsigned                        outstanding,
	output int unsigned                        mismatches
);
	import trm_pkg::*;

	typedef struct packed {
		logic [PC_W-1:0]   next_pc;
		logic              halted;
		logic              print_valid;
		logic [WORD_W-1:0] print_value;
	} pc_report_t;

	typedef struct packed {
		pc_report_t        report;
		logic [PC_W-1:0]   pc;
		logic              halt;
		logic              wr_en;
		logic [FIELD_W-1:0] wr_idx;
		logic [WORD_W-1:0] wr_val;
	} exec_step_t;

	logic [WORD_W-1:0] regs_q [8];
	logic [PC_W-1:0]   pc_q;
	logic [PC_W-1:0]   len_q;
	logic              halt_q;
	exec_step_t        step_now;
	pc_report_t        owed_reports [$];

	function automatic exec_step_t execute_instr(
		input logic [PC_W-1:0]          pc,
		input logic                     halt,
		input logic [PC_W-1:0]          len,
		input cmd_t                     cmd,
		input logic [FIELD_W-1:0]       dst,
		input logic [WORD_W-1:0]        a,
		input logic [WORD_W-1:0]        b,
		input logic signed [IMM_W-1:0]  imm
	);
		exec_step_t st;
		int lim;
		int target;
		st = '0;
		lim = (int'(len) > PC_LIMIT) ? PC_LIMIT : int'(len);
		st.pc = pc;
		st.halt = halt;
		// outside the program: consume the request, report the pc as it stands
		if (halt || int'(pc) >= lim) begin
			st.report.next_pc = pc;
			st.report.halted = 1'b1;
			return st;
		end
		target = int'(pc) + 1;
		st.wr_idx = dst;
		case (cmd)
			CMD_J: target = int'(pc) + int'(imm);
			CMD_PRT: begin
				st.report.print_valid = 1'b1;
				st.report.print_value = a;
			end
			CMD_BEQZ: if (a == '0) target = int'(pc) + int'(imm);
			CMD_ADDI: begin
				st.wr_en = 1'b1;
				st.wr_val = a + {{(WORD_W-IMM_W){imm[IMM_W-1]}}, imm};
			end
			CMD_SLT: begin
				st.wr_en = 1'b1;
				st.wr_val = {{(WORD_W-1){1'b0}}, ($signed(b) > $signed(a))};
			end
			CMD_ADD: begin
				st.wr_en = 1'b1;
				st.wr_val = a + b;
			end
			CMD_SUB: begin
				st.wr_en = 1'b1;
				st.wr_val = a - b;
			end
			default: ;
		endcase
		if (target < 0 || target >= lim) begin
			st.pc = PC_W'(lim);
			st.halt = 1'b1;
		end else begin
			st.pc = PC_W'(target);
		end
		st.report.next_pc = st.pc;
		st.report.halted = st.halt;
		return st;
	endfunction

	function automatic int unsigned field_differs(input string field,
			input logic [WORD_W-1:0] want, input logic [WORD_W-1:0] got);
		if (want === got)
			return 0;
		$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
		return 1;
	endfunction

	// pc_ahead: pc once the request now offered is taken, so stimulus can stay in range
	always_comb begin
		step_now = execute_instr(pc_q, halt_q, len_q, cmd_t'(command), dst_reg,
			regs_q[src1_reg], regs_q[src2_reg], immediate);
		pc_ahead = in_valid ? step_now.pc : pc_q;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		pc_report_t want;
		int unsigned bad;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				regs_q[i] <= '0;
			pc_q <= '0;
			len_q <= '0;
			halt_q <= 1'b0;
			owed_reports.delete();
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			bad = 0;
			if (psel && penable && pwrite && pready && paddr[2] == REG_PROG_LEN)
				len_q <= pwdata[PC_W-1:0];
			// compare before queueing so a result never meets its own request
			if (out_valid && out_ready) begin
				if (owed_reports.size() == 0) begin
					$error("result with next_pc 0x%0h arrived with nothing expected", next_pc);
					bad++;
				end else begin
					want = owed_reports.pop_front();
					bad += field_differs("next_pc", WORD_W'(want.next_pc), WORD_W'(next_pc));
					bad += field_differs("halted", WORD_W'(want.halted), WORD_W'(halted));
					bad += field_differs("print_valid", WORD_W'(want.print_valid),
						WORD_W'(print_valid));
					bad += field_differs("print_value", want.print_value, print_value);
				end
			end
			if (in_valid && in_ready) begin
				pc_q <= step_now.pc;
				halt_q <= step_now.halt;
				if (step_now.wr_en)
					regs_q[step_now.wr_idx] <= step_now.wr_val;
				owed_reports.push_back(step_now.report);
			end
			outstanding <= owed_reports.size();
			mismatches <= mismatches + bad;
		end
	end

endmodule

>>> test/tb_tiny_register_machine_execute_core.sv
// Testbench top for the tiny register machine execute core: clock, reset,
// APB writes of the program length and instruction requests under varied stalls.
// Depends on trm_pkg, the core and trm_execute_checker.
module tb_tiny_register_machine_execute_core;
	import trm_pkg::*;

	// command code with no operation behind it
	localparam logic [FIELD_W-1:0] CMD_NOP = 3'd7;
	localparam logic [APB_ADDR_W-1:0] PROG_LEN_ADDR = {REG_PROG_LEN, 2'b00};
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 48;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS = 300;

	typedef struct packed {
		cmd_t                  cmd;
		logic [FIELD_W-1:0]    dst;
		logic [FIELD_W-1:0]    src1;
		logic [FIELD_W-1:0]    src2;
		logic signed [IMM_W-1:0] imm;
	} instr_t;

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_ADDR_W-1:0]   paddr;
	logic [APB_DATA_W-1:0]   pwdata;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;
	logic                    in_valid;
	logic                    in_ready;
	logic [FIELD_W-1:0]      command;
	logic [FIELD_W-1:0]      dst_reg;
	logic [FIELD_W-1:0]      src1_reg;
	logic [FIELD_W-1:0]      src2_reg;
	logic signed [IMM_W-1:0] immediate;
	logic                    out_valid;
	logic                    out_ready;
	logic [PC_W-1:0]         next_pc;
	logic                    halted;
	logic                    print_valid;
	logic signed [WORD_W-1:0] print_value;

	logic [PC_W-1:0]         pc_ahead;
	int unsigned             outstanding;
	int unsigned             mismatches;

	int idle_pct = 0;
	int stall_pct = 0;
	int cur_len = 0;
	int hold_events = 0;
	int holds_done = 0;
	int cycles = 0;

	tiny_register_machine_execute_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .dst_reg(dst_reg), .src1_reg(src1_reg),
		.src2_reg(src2_reg), .immediate(immediate),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .halted(halted),
		.print_valid(print_valid), .print_value(print_value)
	);

	trm_execute_checker chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .dst_reg(dst_reg), .src1_reg(src1_reg),
		.src2_reg(src2_reg), .immediate(immediate),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .halted(halted),
		.print_valid(print_valid), .print_value(print_value),
		.pc_ahead(pc_ahead), .outstanding(outstanding), .mismatches(mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_tiny_register_machine_execute_core: errors");
			$finish;
		end
	end

	// receiver: random stalls, or one long hold-off per request from the sender side
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_events != holds_done) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic int eff_len();
		return (cur_len > PC_LIMIT) ? PC_LIMIT : cur_len;
	endfunction

	// random instruction that keeps the pc inside [0, lim)
	function automatic instr_t make_instr(input int pc, input int lim);
		instr_t it;
		int pick;
		it.cmd = CMD_ADD;
		it.dst = FIELD_W'($urandom_range(7));
		it.src1 = FIELD_W'($urandom_range(7));
		it.src2 = FIELD_W'($urandom_range(7));
		it.imm = IMM_W'($urandom);
		if (pc >= lim) begin
			it.cmd = cmd_t'($urandom_range(7));
			return it;
		end
		pick = $urandom_range(99);
		// last slot: only a jump can stay inside
		if (pc + 1 >= lim)
			pick = 0;
		if (pick < 10)
			it.cmd = CMD_J;
		else if (pick < 22)
			it.cmd = CMD_PRT;
		else if (pick < 34)
			it.cmd = CMD_BEQZ;
		else if (pick < 56)
			it.cmd = CMD_ADDI;
		else if (pick < 68)
			it.cmd = CMD_SLT;
		else if (pick < 82)
			it.cmd = CMD_ADD;
		else if (pick < 96)
			it.cmd = CMD_SUB;
		else
			it.cmd = cmd_t'(CMD_NOP);
		if (it.cmd inside {CMD_J, CMD_BEQZ})
			it.imm = IMM_W'(int'($urandom_range(lim - 1)) - pc);
		else if (it.cmd == CMD_ADDI && $urandom_range(3) == 0)
			it.imm = IMM_W'(int'($urandom_range(16)) - 8);
		// doubling chains push values through the 32-bit wrap
		if (it.cmd == CMD_ADD && $urandom_range(3) == 0) begin
			it.src1 = it.dst;
			it.src2 = it.dst;
		end
		return it;
	endfunction

	task automatic issue(input bit random_pick, input instr_t fixed);
		instr_t it;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		it = random_pick ? make_instr(int'(pc_ahead), eff_len()) : fixed;
		in_valid <= 1'b1;
		command <= it.cmd;
		dst_reg <= it.dst;
		src1_reg <= it.src1;
		src2_reg <= it.src2;
		immediate <= it.imm;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send(input cmd_t c, input logic [FIELD_W-1:0] d,
			input logic [FIELD_W-1:0] s1, input logic [FIELD_W-1:0] s2,
			input logic signed [IMM_W-1:0] imm);
		issue(1'b0, {c, d, s1, s2, imm});
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_prog_len(input int v);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PROG_LEN_ADDR;
		pwdata <= APB_DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		cur_len = v;
	endtask

	initial begin
		int pc;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		command = '0;
		dst_reg = '0;
		src1_reg = '0;
		src2_reg = '0;
		immediate = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length after reset: requests are consumed, nothing changes
		send(CMD_PRT, 3'd0, 3'd0, 3'd0, 16'sd0);
		send(CMD_ADDI, 3'd1, 3'd0, 3'd0, 16'sd100);

		// length past the program depth is clamped to the full depth
		write_prog_len(511);
		send(CMD_ADDI, 3'd1, 3'd0, 3'd0, 16'sh7fff);
		send(CMD_ADDI, 3'd2, 3'd0, 3'd0, 16'sh8000);
		send(CMD_ADD, 3'd3, 3'd1, 3'd2, 16'sd0);
		send(CMD_SUB, 3'd4, 3'd2, 3'd1, 16'sd0);
		send(CMD_SLT, 3'd5, 3'd2, 3'd1, 16'sd0);
		send(CMD_SLT, 3'd6, 3'd1, 3'd2, 16'sd0);
		send(CMD_PRT, 3'd0, 3'd3, 3'd0, 16'sd0);
		send(CMD_PRT, 3'd0, 3'd4, 3'd0, 16'sd0);
		send(CMD_BEQZ, 3'd0, 3'd6, 3'd0, 16'sd3);
		send(CMD_BEQZ, 3'd0, 3'd5, 3'd0, -16'sd2);
		send(CMD_J, 3'd0, 3'd0, 3'd0, -16'sd12);
		send(CMD_J, 3'd0, 3'd0, 3'd0, 16'sd0);
		send(cmd_t'(CMD_NOP), 3'd7, 3'd7, 3'd7, 16'shffff);
		send(CMD_ADD, 3'd7, 3'd7, 3'd7, 16'sd0);
		send(CMD_PRT, 3'd0, 3'd1, 3'd0, 16'sd0);

		// pc now 3: shrink the program under it, then widen it again
		write_prog_len(2);
		send(CMD_PRT, 3'd0, 3'd1, 3'd0, 16'sd0);
		write_prog_len(256);
		send(CMD_J, 3'd0, 3'd0, 3'd0, -16'sd3);
		write_prog_len(1);
		send(CMD_J, 3'd0, 3'd0, 3'd0, 16'sd0);
		write_prog_len(256);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 70; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 70; end
				default: begin idle_pct = 10; stall_pct = 10; end
			endcase
			drain();
			pc = int'(pc_ahead);
			if (ph == 2) begin
				write_prog_len($urandom_range(pc));
				repeat (3) issue(1'b1, '0);
			end
			case (ph)
				0: write_prog_len(256);
				1: write_prog_len(pc + 2 + $urandom_range(14));
				2: write_prog_len($urandom_range(300, pc + 1));
				default: write_prog_len(511);
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold the receiver off while requests keep coming
				if (ph == 0 && n == 100)
					hold_events <= hold_events + 1;
				if (n == 200)
					drain();
				issue(1'b1, '0);
			end
		end

		// leave the program one way, then check the halt sticks
		idle_pct = 0;
		stall_pct = 20;
		write_prog_len(256);
		pc = int'(pc_ahead);
		send(CMD_J, 3'd0, 3'd0, 3'd0, IMM_W'(254 - pc));
		case ($urandom_range(3))
			0: send(CMD_J, 3'd0, 3'd0, 3'd0, 16'sh8000);
			1: send(CMD_J, 3'd0, 3'd0, 3'd0, 16'sh7fff);
			2: begin
				send(CMD_SUB, 3'd3, 3'd3, 3'd3, 16'sd0);
				send(CMD_BEQZ, 3'd0, 3'd3, 3'd0, 16'sd1);
			end
			default: begin
				send(CMD_ADD, 3'd4, 3'd1, 3'd2, 16'sd0);
				send(CMD_PRT, 3'd0, 3'd4, 3'd0, 16'sd0);
			end
		endcase
		send(CMD_PRT, 3'd0, 3'd1, 3'd0, 16'sd0);
		send(CMD_ADDI, 3'd5, 3'd5, 3'd0, 16'sd1);
		send(CMD_J, 3'd0, 3'd0, 3'd0, -16'sd1);
		write_prog_len(0);
		write_prog_len(256);
		send(CMD_PRT, 3'd0, 3'd5, 3'd0, 16'sd0);
		send(CMD_J, 3'd0, 3'd0, 3'd0, -16'sd200);

		drain();
		if (mismatches == 0)
			$display("tb_tiny_register_machine_execute_core: clean");
		else
			$display("tb_tiny_register_machine_execute_core: errors");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/trm_pkg.sv
rtl/core/trm_regfile.sv
rtl/core/tiny_register_machine_execute_core.sv
test/trm_execute_checker.sv
test/tb_tiny_register_machine_execute_core.sv
